// ===== sv/arrival_controller_brake_hysteresis_unit_assert.svh =====
// ----------------------------------------------------------------------------
// arrival controller assertion macros
// shared assertion forms for the checker of the arrival controller
// ----------------------------------------------------------------------------
`ifndef ARRIVAL_CONTROLLER_BRAKE_HYSTERESIS_UNIT_ASSERT_SVH
`define ARRIVAL_CONTROLLER_BRAKE_HYSTERESIS_UNIT_ASSERT_SVH

// checked outside reset
`define ACBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset too
`define ACBH_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/acbh_pkg.sv =====
// ----------------------------------------------------------------------------
// acbh_pkg
// codes, limits and unit request types of the arrival controller
// ----------------------------------------------------------------------------
package acbh_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [2:0] ACT_IDLE    = 3'd0;
  localparam logic [2:0] ACT_ARRIVED = 3'd1;
  localparam logic [2:0] ACT_STALL   = 3'd2;
  localparam logic [2:0] ACT_BAD_DIR = 3'd3;
  localparam logic [2:0] ACT_BRAKE   = 3'd4;
  localparam logic [2:0] ACT_DRIVE   = 3'd5;

  localparam logic [2:0] REG_TARGET_X   = 3'd0;
  localparam logic [2:0] REG_TARGET_Y   = 3'd1;
  localparam logic [2:0] REG_RADIUS     = 3'd2;
  localparam logic [2:0] REG_MOVE_SPEED = 3'd3;
  localparam logic [2:0] REG_SLOW_MULT  = 3'd4;
  localparam logic [2:0] REG_MIN_SCALE  = 3'd5;
  localparam logic [2:0] REG_STUCK_TIME = 3'd6;
  localparam logic [2:0] REG_MODE       = 3'd7;

  localparam logic [20:0] RADIUS_MIN = 21'd16;
  localparam logic [20:0] RADIUS_MAX = 21'd1048576;
  localparam logic [15:0] SPEED_MIN  = 16'd1638;
  localparam logic [15:0] SPEED_MAX  = 16'd32768;
  localparam logic [14:0] SCALE_ONE  = 15'd16384;
  localparam logic [14:0] STUCK_MIN  = 15'd500;
  localparam logic [14:0] STUCK_MAX  = 15'd30000;
  localparam logic [31:0] US_PER_MS  = 32'd1000;

  localparam logic [47:0] VSQ_RELEASE = 48'd256;
  localparam logic [47:0] VSQ_REENTER = 48'd102400;

  localparam logic [5:0] STEPS_BRAKE = 6'd48;
  localparam logic [5:0] STEPS_FRAC  = 6'd15;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
  } sqrt_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
    logic [5:0]  steps;
  } div_req_t;

endpackage

// ===== sv/acbh_in_if.sv =====
// ----------------------------------------------------------------------------
// acbh_in_if
// request channel of the arrival controller
// ----------------------------------------------------------------------------
interface acbh_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [30:0] pos_x;
  logic signed [30:0] pos_y;
  logic signed [23:0] vel_x;
  logic signed [23:0] vel_y;
  logic [23:0]        brake_decel;
  logic [19:0]        delta_time;

  modport source (output valid, op, pos_x, pos_y, vel_x, vel_y, brake_decel, delta_time,
                  input ready);
  modport sink (input valid, op, pos_x, pos_y, vel_x, vel_y, brake_decel, delta_time,
                output ready);
endinterface

// ===== sv/acbh_out_if.sv =====
// ----------------------------------------------------------------------------
// acbh_out_if
// result channel of the arrival controller
// ----------------------------------------------------------------------------
interface acbh_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [15:0]        drive_scale;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic               moving;

  modport source (output valid, action, drive_scale, dir_x, dir_y, moving, input ready);
  modport sink (input valid, action, drive_scale, dir_x, dir_y, moving, output ready);
endinterface

// ===== sv/acbh_sqrt.sv =====
// ----------------------------------------------------------------------------
// acbh_sqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module acbh_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  acbh_pkg::sqrt_req_t req,
  output logic              done,
  output logic [31:0]       root
);
  import acbh_pkg::*;

  logic [63:0] rem;
  logic [63:0] res;
  logic [4:0]  k;
  logic        active;
  logic [63:0] b;
  logic [63:0] trial;

  assign b     = 64'd1 << {k, 1'b0};
  assign trial = res + b;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem    <= req.x;
        res    <= '0;
        k      <= 5'd31;
        active <= 1'b1;
      end else if (active) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + b;
        end else begin
          res <= res >> 1;
        end
        if (k == 5'd0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          k <= k - 5'd1;
        end
      end
    end
  end
endmodule

// ===== sv/acbh_div.sv =====
// ----------------------------------------------------------------------------
// acbh_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module acbh_div (
  input  logic             clk,
  input  logic             rst,
  input  acbh_pkg::div_req_t req,
  output logic             done,
  output logic [47:0]      quo
);
  import acbh_pkg::*;

  logic [32:0] rem;
  logic [63:0] low;
  logic [31:0] den;
  logic [5:0]  cnt;
  logic        active;
  logic [5:0]  bit_idx;
  logic [33:0] t;
  logic        ge;

  assign bit_idx = cnt - 6'd1;
  assign t       = {rem, low[bit_idx]};
  assign ge      = t >= {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem    <= 33'(req.num >> req.steps);
        low    <= req.num;
        den    <= req.den;
        cnt    <= req.steps;
        quo    <= '0;
        active <= 1'b1;
      end else if (active) begin
        rem <= ge ? 33'(t - {2'b00, den}) : t[32:0];
        quo <= {quo[46:0], ge};
        cnt <= bit_idx;
        if (cnt == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== sv/arrival_controller_brake_hysteresis_unit.sv =====
// ----------------------------------------------------------------------------
// arrival_controller_brake_hysteresis_unit
// point-approach controller with brake hysteresis and slowdown zone
// ----------------------------------------------------------------------------
// in_ch takes start, tick and stop requests; out_ch returns one result per
// request: action, unit direction, drive scale and the armed flag.
// cfg_we/cfg_idx/cfg_data write the eight setup registers; the user must write
// them only while idle, since the block does not enforce it. one request is
// worked at a time; in_ch.ready is high only when idle. start, stop and idle
// ticks use squares on the shared multiplier, then the 32-step square root;
// an armed tick can add the brake distance divide, the two direction divides,
// the brake decision, the slowdown scale divide and the drive scale, all on
// the shared divider and multiplier. the result sits in an output register;
// a new request is taken while it waits, and the next result holds until the
// receiver takes the old one. reset (synchronous, active high) disarms
// motion, clears progress tracking, reloads register defaults and empties the
// output register.
// ----------------------------------------------------------------------------
module arrival_controller_brake_hysteresis_unit #(
  parameter int unsigned PROGRESS_EPSILON = 16
) (
  input  logic        clk,
  input  logic        rst,
  acbh_in_if.sink     in_ch,
  acbh_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [30:0] cfg_data
);
  import acbh_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_SQRT, S_EVAL, S_DIVB,
    S_DXS, S_DXW, S_DYS, S_DYW, S_BRK, S_SLM, S_SLW, S_DRV, S_DRV2, S_FIN
  } state_t;

  state_t state;

  // setup registers
  logic [30:0] target_x, target_y;
  logic [20:0] acceptance_radius;
  logic [15:0] move_speed, slowdown_multiplier;
  logic [14:0] min_slowdown_scale, stuck_time;
  logic [1:0]  mode_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x            <= '0;
      target_y            <= '0;
      acceptance_radius   <= 21'd800;
      move_speed          <= 16'd16384;
      slowdown_multiplier <= 16'd768;
      min_slowdown_scale  <= 15'd3277;
      stuck_time          <= 15'd2000;
      mode_flags          <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TARGET_X:   target_x <= cfg_data;
        REG_TARGET_Y:   target_y <= cfg_data;
        REG_RADIUS:     acceptance_radius <= cfg_data[20:0];
        REG_MOVE_SPEED: move_speed <= cfg_data[15:0];
        REG_SLOW_MULT:  slowdown_multiplier <= cfg_data[15:0];
        REG_MIN_SCALE:  min_slowdown_scale <= cfg_data[14:0];
        REG_STUCK_TIME: stuck_time <= cfg_data[14:0];
        REG_MODE:       mode_flags <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // clamped setup values
  logic [20:0] r_c;
  logic [15:0] ms_c;
  logic [14:0] mins_c, stuck_c;

  always_comb begin
    r_c     = acceptance_radius < RADIUS_MIN ? RADIUS_MIN :
              (acceptance_radius > RADIUS_MAX ? RADIUS_MAX : acceptance_radius);
    ms_c    = move_speed < SPEED_MIN ? SPEED_MIN :
              (move_speed > SPEED_MAX ? SPEED_MAX : move_speed);
    mins_c  = min_slowdown_scale > SCALE_ONE ? SCALE_ONE : min_slowdown_scale;
    stuck_c = stuck_time < STUCK_MIN ? STUCK_MIN :
              (stuck_time > STUCK_MAX ? STUCK_MAX : stuck_time);
  end

  // request registers
  logic [1:0]  op;
  logic [31:0] adx, ady;
  logic        sx, sy, dz;
  logic [23:0] avx, avy, decel;
  logic [19:0] dt;

  // controller state
  logic        armed, rel;
  logic [31:0] best, stall;

  // working registers
  logic [63:0] prod, acc;
  logic [47:0] vsq, bq;
  logic [28:0] zone;
  logic [24:0] stuck_us;
  logic [31:0] d;
  logic [14:0] qx, qy, scale;
  logic [2:0]  r_act;
  logic [15:0] r_drive, r_dx, r_dy;

  // output register
  logic        out_valid;
  logic [2:0]  o_action;
  logic [15:0] o_drive, o_dx, o_dy;
  logic        o_moving;

  logic [31:0] mul_a, mul_b;
  sqrt_req_t   sq_req;
  div_req_t    div_req;
  logic        sq_done, div_done;
  logic [31:0] sq_root;
  logic [47:0] div_quo;

  acbh_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sq_req), .done(sq_done), .root(sq_root));
  acbh_div  u_div  (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quo(div_quo));

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // accept-time differences
  logic signed [31:0] dx_in, dy_in;
  logic signed [23:0] vx_in, vy_in;

  assign dx_in = $signed({target_x[30], target_x}) - $signed({in_ch.pos_x[30], in_ch.pos_x});
  assign dy_in = $signed({target_y[30], target_y}) - $signed({in_ch.pos_y[30], in_ch.pos_y});
  assign vx_in = in_ch.vel_x;
  assign vy_in = in_ch.vel_y;

  // evaluation terms
  logic        d_le_r, progress, stalled_now, need_bdiv, tick_go;
  logic [32:0] stall_sum;
  logic [31:0] stall_sat;
  logic [47:0] bdist, r15, thr;
  logic        brake, in_zone, brk_hold, brk_release, brk_reenter;

  always_comb begin
    d_le_r      = d <= {11'd0, r_c};
    progress    = $signed({2'b00, d}) <
                  ($signed({2'b00, best}) - $signed(34'(PROGRESS_EPSILON)));
    stall_sum   = {1'b0, stall} + {13'd0, dt};
    stall_sat   = stall_sum[32] ? 32'hFFFF_FFFF : stall_sum[31:0];
    stalled_now = mode_flags[1] && !progress && (stall_sat >= {7'd0, stuck_us});
    need_bdiv   = (decel != 24'd0) && (vsq != 48'd0);
    tick_go     = (op == OP_TICK) && armed && !d_le_r && !stalled_now && !dz;
    bdist       = bq + 48'(r_c >> 1);
    r15         = 48'(({1'b0, r_c, 1'b0} + {2'b00, r_c}) >> 1);
    thr         = bdist > r15 ? bdist : r15;
    brake       = {16'd0, d} <= thr;
    in_zone     = mode_flags[0] && (d <= {3'd0, zone});
    brk_hold    = brake && !rel && (vsq > VSQ_RELEASE);
    brk_release = brake && !rel && (vsq <= VSQ_RELEASE);
    brk_reenter = brake && rel && (vsq >= VSQ_REENTER);
  end

  // shared unit operands
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    sq_req  = '0;
    div_req = '0;
    unique case (state)
      S_M0: begin mul_a = adx; mul_b = adx; end
      S_M1: begin mul_a = ady; mul_b = ady; end
      S_M2: begin
        mul_a        = {8'd0, avx};
        mul_b        = {8'd0, avx};
        sq_req.start = 1'b1;
        sq_req.x     = acc + prod;
      end
      S_M3: begin mul_a = {8'd0, avy}; mul_b = {8'd0, avy}; end
      S_M4: begin mul_a = {11'd0, r_c}; mul_b = {16'd0, slowdown_multiplier}; end
      S_M5: begin mul_a = {17'd0, stuck_c}; mul_b = US_PER_MS; end
      S_EVAL: begin
        div_req.start = tick_go && need_bdiv;
        div_req.num   = {16'd0, vsq};
        div_req.den   = {7'd0, decel, 1'b0};
        div_req.steps = STEPS_BRAKE;
      end
      S_DXS: begin
        div_req.start = 1'b1;
        div_req.num   = ({32'd0, adx} << 14) + {33'd0, d[31:1]};
        div_req.den   = d;
        div_req.steps = STEPS_FRAC;
      end
      S_DYS: begin
        div_req.start = 1'b1;
        div_req.num   = ({32'd0, ady} << 14) + {33'd0, d[31:1]};
        div_req.den   = d;
        div_req.steps = STEPS_FRAC;
      end
      S_BRK: begin
        mul_a = {17'd0, 15'(SCALE_ONE - mins_c)};
        mul_b = d - {11'd0, r_c};
      end
      S_SLM: begin
        div_req.start = 1'b1;
        div_req.num   = prod;
        div_req.den   = {3'd0, zone} - {11'd0, r_c};
        div_req.steps = STEPS_FRAC;
      end
      S_DRV: begin mul_a = {16'd0, ms_c}; mul_b = {17'd0, scale}; end
      default: ;
    endcase
  end

  assign in_ch.ready        = (state == S_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.action      = o_action;
  assign out_ch.drive_scale = o_drive;
  assign out_ch.dir_x       = o_dx;
  assign out_ch.dir_y       = o_dy;
  assign out_ch.moving      = o_moving;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      armed     <= 1'b0;
      rel       <= 1'b0;
      best      <= '0;
      stall     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && (state != S_FIN)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op    <= in_ch.op;
            adx   <= dx_in[31] ? 32'(-dx_in) : 32'(dx_in);
            ady   <= dy_in[31] ? 32'(-dy_in) : 32'(dy_in);
            sx    <= dx_in[31];
            sy    <= dy_in[31];
            dz    <= (dx_in == 32'sd0) && (dy_in == 32'sd0);
            avx   <= vx_in[23] ? 24'(-vx_in) : 24'(vx_in);
            avy   <= vy_in[23] ? 24'(-vy_in) : 24'(vy_in);
            decel <= in_ch.brake_decel;
            dt    <= in_ch.delta_time;
            state <= S_M0;
          end
        end
        S_M0: state <= S_M1;
        S_M1: begin acc <= prod; state <= S_M2; end
        S_M2: state <= S_M3;
        S_M3: begin acc <= prod; state <= S_M4; end
        S_M4: begin vsq <= 48'(acc + prod); state <= S_M5; end
        S_M5: begin zone <= 29'(prod >> 8); state <= S_M6; end
        S_M6: begin stuck_us <= prod[24:0]; state <= S_SQRT; end
        S_SQRT: begin
          if (sq_done) begin
            d     <= sq_root;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          r_act   <= ACT_IDLE;
          r_drive <= '0;
          r_dx    <= '0;
          r_dy    <= '0;
          state   <= S_FIN;
          unique case (op)
            OP_START: begin
              if (d_le_r) begin
                r_act <= ACT_ARRIVED;
              end else begin
                armed <= 1'b1;
                best  <= d;
                stall <= '0;
                rel   <= 1'b0;
              end
            end
            OP_STOP: armed <= 1'b0;
            OP_TICK: begin
              if (armed) begin
                if (d_le_r) begin
                  r_act <= ACT_ARRIVED;
                  armed <= 1'b0;
                end else begin
                  if (mode_flags[1]) begin
                    if (progress) begin
                      best  <= d;
                      stall <= '0;
                    end else begin
                      stall <= stall_sat;
                    end
                  end
                  if (stalled_now) begin
                    r_act <= ACT_STALL;
                    armed <= 1'b0;
                  end else if (dz) begin
                    r_act <= ACT_BAD_DIR;
                    armed <= 1'b0;
                  end else if (need_bdiv) begin
                    state <= S_DIVB;
                  end else begin
                    bq    <= '0;
                    state <= S_DXS;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        S_DIVB: begin
          if (div_done) begin
            bq    <= div_quo;
            state <= S_DXS;
          end
        end
        S_DXS: state <= S_DXW;
        S_DXW: begin
          if (div_done) begin
            qx    <= div_quo[14:0];
            state <= S_DYS;
          end
        end
        S_DYS: state <= S_DYW;
        S_DYW: begin
          if (div_done) begin
            qy    <= div_quo[14:0];
            state <= S_BRK;
          end
        end
        S_BRK: begin
          r_dx <= sx ? 16'(-{1'b0, qx}) : {1'b0, qx};
          r_dy <= sy ? 16'(-{1'b0, qy}) : {1'b0, qy};
          if (brk_release) rel <= 1'b1;
          if (brk_hold) begin
            r_act <= ACT_BRAKE;
            state <= S_FIN;
          end else if (brk_reenter) begin
            rel   <= 1'b0;
            r_act <= ACT_BRAKE;
            state <= S_FIN;
          end else if (in_zone) begin
            state <= S_SLM;
          end else begin
            scale <= SCALE_ONE;
            state <= S_DRV;
          end
        end
        S_SLM: state <= S_SLW;
        S_SLW: begin
          if (div_done) begin
            scale <= mins_c + div_quo[14:0];
            state <= S_DRV;
          end
        end
        S_DRV: state <= S_DRV2;
        S_DRV2: begin
          r_act   <= ACT_DRIVE;
          r_drive <= 16'((prod + 64'd8192) >> 14);
          state   <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            o_action  <= r_act;
            o_drive   <= r_drive;
            o_dx      <= r_dx;
            o_dy      <= r_dy;
            o_moving  <= armed;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/acbh_checker.sv =====
// ----------------------------------------------------------------------------
// acbh_checker
// port-level checks of the arrival controller, bound to the top level
// ----------------------------------------------------------------------------
`include "arrival_controller_brake_hysteresis_unit_assert.svh"

module acbh_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_action,
  input logic [15:0] out_drive_scale,
  input logic       out_moving
);
  import acbh_pkg::*;

  `ACBH_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result valid right after reset")
  `ACBH_ASSERT(a_busy_after_req, in_valid && in_ready |=> !in_ready, "request taken while busy")
  `ACBH_ASSERT(a_drive_only, out_valid && out_action != ACT_DRIVE |-> out_drive_scale == 16'd0, "drive scale outside drive")
  `ACBH_ASSERT(a_armed_match, out_valid && (out_action == ACT_BRAKE || out_action == ACT_DRIVE) |-> out_moving, "motion result while disarmed")
  `ACBH_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_action), "stalled result changed")
endmodule

bind arrival_controller_brake_hysteresis_unit acbh_checker u_acbh_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_action(out_ch.action),
  .out_drive_scale(out_ch.drive_scale),
  .out_moving(out_ch.moving)
);
